// ===== hdl/kd_tree_point_order_macros.svh =====
// assertion macros for the kd-tree point ordering block
`ifndef KD_TREE_POINT_ORDER_MACROS_SVH
`define KD_TREE_POINT_ORDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define KDPO_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("kdpo check failed");

// next-cycle implication, checked out of reset
`define KDPO_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("kdpo check failed");

`endif

// ===== hdl/kdpo_pkg.sv =====
// shared types, constants and helpers of the kd-tree point ordering block
`timescale 1ns / 1ps
package kdpo_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DIMS       = 3;
  localparam int COORD_W        = 32;
  localparam int POINT_W        = 3 * COORD_W;

  localparam logic [1:0] DIMS_RESET  = 2'd2;
  localparam logic [1:0] START_RESET = 2'd0;

  // configuration register indexes
  localparam logic CFG_DIMS  = 1'b0;
  localparam logic CFG_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_PASS,
    ST_RUN,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } kdpo_state_t;

  // clamp dims to 1..MAX_DIMS
  function automatic logic [1:0] clamp_dims(input logic [1:0] d);
    logic [1:0] r;
    r = d;
    if (d == 2'd0) r = 2'd1;
    if (d > 2'(MAX_DIMS)) r = 2'(MAX_DIMS);
    return r;
  endfunction

  // small modulo by repeated subtraction, a < 4, d >= 1
  function automatic logic [1:0] mod_small(input logic [1:0] a, input logic [1:0] d);
    logic [1:0] r;
    r = a;
    for (int s = 0; s < 3; s++) begin
      if (r >= d) r = r - d;
    end
    return r;
  endfunction

endpackage

// ===== hdl/kd_tree_point_order.sv =====
// top level of the kd-tree point ordering block
`timescale 1ns / 1ps
// Points stream in one per cycle while in_tready is high and go into bank 0.
// The item with in_tlast set, or the MAX_POINTS-th item, closes the set;
// in_tready then stays low until every point has been sent back out in
// kd-tree order, with out_tlast on the final one. Segments wait on a small
// stack; each one is sorted by coordinate magnitude with a bottom-up merge
// sort that ping-pongs between two point banks, one merged point per cycle
// through a single shared compare unit. Ties go to the right-hand run,
// which gives the same order as a top-down merge sort with that rule.
// An odd number of passes is followed by a copy pass back into bank 0.
// Each pass over a segment sets up every run in the RUN and PRIME states and
// then merges it point by point; every segment adds a pop and a final pass
// check, and every emitted point is read in EMIT_RD and then offered in
// EMIT_OUT, which waits on out_tready. Configuration is sampled when a set
// closes.
module kd_tree_point_order #(
  parameter int MAX_POINTS = kdpo_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [kdpo_pkg::POINT_W-1:0] in_tdata,   // coord_a, coord_b, coord_c
  input  logic                         in_tlast,   // last_point
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [kdpo_pkg::POINT_W-1:0] out_tdata,  // out_a, out_b, out_c
  output logic                         out_tlast,  // out_last
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [1:0]                   cfg_data
);

`include "kd_tree_point_order_macros.svh"

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int WW  = CW + 1;
  localparam int STK = AW + 2;
  localparam int SW  = $clog2(STK + 1);
  localparam int SIW = $clog2(STK);

  // configuration
  logic [1:0] cfg_dims_r, cfg_start_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dims_r  <= kdpo_pkg::DIMS_RESET;
      cfg_start_r <= kdpo_pkg::START_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kdpo_pkg::CFG_DIMS:  cfg_dims_r  <= cfg_data;
        kdpo_pkg::CFG_START: cfg_start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  kdpo_pkg::kdpo_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;   // points in the set
  logic [CW-1:0] e_r, e_nxt;           // emit index
  logic [1:0]    dims_r, dims_nxt;     // clamped dims of this set
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]    ax_r, ax_nxt;
  logic [WW-1:0] w_r, w_nxt;           // run width of this pass
  logic          bank_r, bank_nxt;     // bank that holds the source
  logic [CW-1:0] s_r, s_nxt;           // run start
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] mid_r, mid_nxt, end_r, end_nxt;
  logic [SW-1:0] sp_r, sp_nxt;

  // segment stack
  logic [CW-1:0] stk_lo_r [STK];
  logic [CW-1:0] stk_hi_r [STK];
  logic [1:0]    stk_ax_r [STK];
  logic [SIW-1:0] top_idx;
  logic [CW-1:0]  pop_lo, pop_hi, pop_n, half_pt;
  logic [1:0]     pop_ax, child_ax;
  logic           do_split, do_start;

  // bank ports
  logic [AW-1:0]               rd_a, rd_b;
  logic [kdpo_pkg::POINT_W-1:0] d0a, d0b, d1a, d1b, src_l, src_r, merge_pt;
  logic                        we0, we1;
  logic [AW-1:0]               wa0, wa1;
  logic [kdpo_pkg::POINT_W-1:0] wd0;
  logic                        left_lt, lexh, rexh, take_r;
  logic [WW:0]                 sum1, sum2;
  logic                        in_hs, last_in;

  assign in_hs   = in_tvalid && in_tready;
  assign last_in = in_tlast || (count_r + 1'b1 == CW'(MAX_POINTS));
  assign top_idx = SIW'(sp_r - 1'b1);
  assign pop_lo  = stk_lo_r[top_idx];
  assign pop_hi  = stk_hi_r[top_idx];
  assign pop_ax  = stk_ax_r[top_idx];
  assign pop_n   = pop_hi - pop_lo;
  assign half_pt = pop_lo + (pop_n >> 1);
  assign child_ax = (ax_nxt + 1'b1 == dims_r) ? 2'd0 : ax_nxt + 1'b1;
  assign do_split = (state_r == kdpo_pkg::ST_POP) && (sp_r != '0) && (pop_n >= CW'(2));
  assign do_start = (state_r == kdpo_pkg::ST_IDLE) && in_hs && last_in;

  assign src_l = bank_r ? d1a : d0a;
  assign src_r = bank_r ? d1b : d0b;

  kdpo_cmp u_cmp (
    .pt_l    (src_l),
    .pt_r    (src_r),
    .axis    (ax_r),
    .left_lt (left_lt)
  );

  assign lexh     = (i_r == mid_r);
  assign rexh     = (j_r == end_r);
  assign take_r   = lexh || (!rexh && !left_lt);
  assign merge_pt = take_r ? src_r : src_l;
  assign sum1     = (WW+1)'(s_r) + (WW+1)'(w_r);
  assign sum2     = sum1 + (WW+1)'(w_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    e_nxt     = e_r;
    dims_nxt  = dims_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ax_nxt    = ax_r;
    w_nxt     = w_r;
    bank_nxt  = bank_r;
    s_nxt     = s_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    end_nxt   = end_r;
    sp_nxt    = sp_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      kdpo_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_hs) begin
          count_nxt = count_r + 1'b1;
          if (last_in) begin
            dims_nxt  = kdpo_pkg::clamp_dims(cfg_dims_r);
            sp_nxt    = SW'(1);
            state_nxt = kdpo_pkg::ST_POP;
          end
        end
      end
      kdpo_pkg::ST_POP: begin
        if (sp_r == '0) begin
          e_nxt     = '0;
          state_nxt = kdpo_pkg::ST_EMIT_RD;
        end else if (pop_n < CW'(2)) begin
          sp_nxt = sp_r - 1'b1;
        end else begin
          // pop one segment, push both halves
          sp_nxt    = sp_r + 1'b1;
          lo_nxt    = pop_lo;
          hi_nxt    = pop_hi;
          ax_nxt    = pop_ax;
          w_nxt     = WW'(1);
          bank_nxt  = 1'b0;
          state_nxt = kdpo_pkg::ST_PASS;
        end
      end
      kdpo_pkg::ST_PASS: begin
        if ((w_r < WW'(hi_r - lo_r)) || bank_r) begin
          s_nxt     = lo_r;
          state_nxt = kdpo_pkg::ST_RUN;
        end else begin
          state_nxt = kdpo_pkg::ST_POP;
        end
      end
      kdpo_pkg::ST_RUN: begin
        if (s_r >= hi_r) begin
          bank_nxt  = !bank_r;
          w_nxt     = w_r << 1;
          state_nxt = kdpo_pkg::ST_PASS;
        end else begin
          mid_nxt   = (sum1 > (WW+1)'(hi_r)) ? hi_r : CW'(sum1);
          end_nxt   = (sum2 > (WW+1)'(hi_r)) ? hi_r : CW'(sum2);
          i_nxt     = s_r;
          j_nxt     = mid_nxt;
          k_nxt     = s_r;
          state_nxt = kdpo_pkg::ST_PRIME;
        end
      end
      kdpo_pkg::ST_PRIME: begin
        state_nxt = kdpo_pkg::ST_MERGE;
      end
      kdpo_pkg::ST_MERGE: begin
        if (take_r) j_nxt = j_r + 1'b1;
        else        i_nxt = i_r + 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == end_r) begin
          s_nxt     = end_r;
          state_nxt = kdpo_pkg::ST_RUN;
        end
      end
      kdpo_pkg::ST_EMIT_RD: begin
        state_nxt = kdpo_pkg::ST_EMIT_OUT;
      end
      kdpo_pkg::ST_EMIT_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (e_r + 1'b1 == count_r) begin
            count_nxt = '0;
            state_nxt = kdpo_pkg::ST_IDLE;
          end else begin
            e_nxt     = e_r + 1'b1;
            state_nxt = kdpo_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = kdpo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdpo_pkg::ST_IDLE;
      count_r <= '0;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    dims_r <= dims_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    ax_r   <= ax_nxt;
    w_r    <= w_nxt;
    bank_r <= bank_nxt;
    s_r    <= s_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    mid_r  <= mid_nxt;
    end_r  <= end_nxt;
    if (do_start) begin
      stk_lo_r[0] <= '0;
      stk_hi_r[0] <= count_nxt;
      stk_ax_r[0] <= kdpo_pkg::mod_small(cfg_start_r,
                                         kdpo_pkg::clamp_dims(cfg_dims_r));
    end
    if (do_split) begin
      // right half below, left half on top
      stk_lo_r[top_idx]        <= half_pt;
      stk_hi_r[top_idx]        <= pop_hi;
      stk_ax_r[top_idx]        <= child_ax;
      stk_lo_r[top_idx + 1'b1] <= pop_lo;
      stk_hi_r[top_idx + 1'b1] <= half_pt;
      stk_ax_r[top_idx + 1'b1] <= child_ax;
    end
  end

  // read addresses follow the heads of both runs, or the emit index
  always_comb begin
    if (state_r == kdpo_pkg::ST_EMIT_RD || state_r == kdpo_pkg::ST_EMIT_OUT) begin
      rd_a = e_r[AW-1:0];
      rd_b = e_r[AW-1:0];
    end else begin
      rd_a = i_nxt[AW-1:0];
      rd_b = j_nxt[AW-1:0];
    end
  end

  assign we0 = (state_r == kdpo_pkg::ST_IDLE) ? in_hs
             : ((state_r == kdpo_pkg::ST_MERGE) && bank_r);
  assign wa0 = (state_r == kdpo_pkg::ST_IDLE) ? count_r[AW-1:0] : k_r[AW-1:0];
  assign wd0 = (state_r == kdpo_pkg::ST_IDLE) ? in_tdata : merge_pt;
  assign we1 = (state_r == kdpo_pkg::ST_MERGE) && !bank_r;
  assign wa1 = k_r[AW-1:0];

  kdpo_bank #(.DEPTH(MAX_POINTS), .AW(AW)) u_bank0 (
    .clk       (clk),
    .wr_en     (we0),
    .wr_addr   (wa0),
    .wr_data   (wd0),
    .rd_addr_a (rd_a),
    .rd_addr_b (rd_b),
    .rd_data_a (d0a),
    .rd_data_b (d0b)
  );

  kdpo_bank #(.DEPTH(MAX_POINTS), .AW(AW)) u_bank1 (
    .clk       (clk),
    .wr_en     (we1),
    .wr_addr   (wa1),
    .wr_data   (merge_pt),
    .rd_addr_a (rd_a),
    .rd_addr_b (rd_b),
    .rd_data_a (d1a),
    .rd_data_b (d1b)
  );

  assign out_tdata = d0a;
  assign out_tlast = (e_r + 1'b1 == count_r);

  `KDPO_ASSERT_IMPL(a_no_overlap, in_tready, !out_tvalid)
  `KDPO_ASSERT_IMPL(a_merge_in_run, state_r == kdpo_pkg::ST_MERGE, k_r < end_r)
  `KDPO_ASSERT_IMPL(a_stack_bound, 1'b1, sp_r <= SW'(STK))
  `KDPO_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast,
                    in_tready && count_r == '0)

endmodule

// ===== hdl/kdpo_bank.sv =====
// point memory: one write port, two registered read ports
`timescale 1ns / 1ps
module kdpo_bank #(
  parameter int DEPTH = kdpo_pkg::MAX_POINTS_DEF,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [kdpo_pkg::POINT_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr_a,
  input  logic [AW-1:0]               rd_addr_b,
  output logic [kdpo_pkg::POINT_W-1:0] rd_data_a,
  output logic [kdpo_pkg::POINT_W-1:0] rd_data_b
);

  logic [kdpo_pkg::POINT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/kdpo_cmp.sv =====
// shared magnitude compare unit: left key strictly below right key
`timescale 1ns / 1ps
module kdpo_cmp (
  input  logic [kdpo_pkg::POINT_W-1:0] pt_l,
  input  logic [kdpo_pkg::POINT_W-1:0] pt_r,
  input  logic [1:0]                   axis,
  output logic                         left_lt
);

  logic [kdpo_pkg::COORD_W-1:0] key_l, key_r, mag_l, mag_r;

  always_comb begin
    case (axis)
      2'd1: begin
        key_l = pt_l[2*kdpo_pkg::COORD_W-1:kdpo_pkg::COORD_W];
        key_r = pt_r[2*kdpo_pkg::COORD_W-1:kdpo_pkg::COORD_W];
      end
      2'd2: begin
        key_l = pt_l[3*kdpo_pkg::COORD_W-1:2*kdpo_pkg::COORD_W];
        key_r = pt_r[3*kdpo_pkg::COORD_W-1:2*kdpo_pkg::COORD_W];
      end
      default: begin
        key_l = pt_l[kdpo_pkg::COORD_W-1:0];
        key_r = pt_r[kdpo_pkg::COORD_W-1:0];
      end
    endcase
    // unsigned magnitude, the most negative value maps to 2^31 exactly
    mag_l   = key_l[kdpo_pkg::COORD_W-1] ? (~key_l + 1'b1) : key_l;
    mag_r   = key_r[kdpo_pkg::COORD_W-1] ? (~key_r + 1'b1) : key_r;
    left_lt = mag_l < mag_r;
  end

endmodule

// ===== dv/kd_tree_point_order_tb.sv =====
// self-checking testbench of the kd-tree point ordering block
`timescale 1ns / 1ps
module kd_tree_point_order_tb;

  typedef logic [kdpo_pkg::POINT_W-1:0] point_t;

  typedef struct {
    point_t pt;
    logic   last;
  } kd_result_t;

  // scoreboard: mirrors the point store, orders each closed set and checks results
  class kd_order_board;
    point_t     pts[kdpo_pkg::MAX_POINTS_DEF];
    point_t     merge_buf[kdpo_pkg::MAX_POINTS_DEF];
    int         n_pts;
    logic [1:0] dims_reg;
    logic [1:0] start_reg;
    kd_result_t pending_q[$];
    int         errors;
    int         checked;

    function new();
      n_pts     = 0;
      dims_reg  = kdpo_pkg::DIMS_RESET;
      start_reg = kdpo_pkg::START_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic idx, logic [1:0] val);
      if (idx == kdpo_pkg::CFG_DIMS) dims_reg = val;
      else start_reg = val;
    endfunction

    // -2^31 wraps to 2^31 as unsigned, the largest magnitude
    function logic [31:0] mag(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
    endfunction

    function void merge_by_axis(int lo, int n, int ax);
      int nl, nr, i, j, k;
      if (n < 2) return;
      nl = n / 2;
      nr = n - nl;
      merge_by_axis(lo, nl, ax);
      merge_by_axis(lo + nl, nr, ax);
      i = 0; j = 0; k = 0;
      while (i < nl && j < nr) begin
        // ties go to the right-hand run
        if (mag(pts[lo+i][ax*kdpo_pkg::COORD_W +: kdpo_pkg::COORD_W]) <
            mag(pts[lo+nl+j][ax*kdpo_pkg::COORD_W +: kdpo_pkg::COORD_W])) begin
          merge_buf[k] = pts[lo+i]; i++;
        end else begin
          merge_buf[k] = pts[lo+nl+j]; j++;
        end
        k++;
      end
      while (i < nl) begin merge_buf[k] = pts[lo+i]; i++; k++; end
      while (j < nr) begin merge_buf[k] = pts[lo+nl+j]; j++; k++; end
      for (int m = 0; m < n; m++) pts[lo+m] = merge_buf[m];
    endfunction

    function void kd_split(int lo, int n, int lvl, int dims);
      if (n < 2) return;
      merge_by_axis(lo, n, (int'(start_reg) + lvl) % dims);
      kd_split(lo, n / 2, lvl + 1, dims);
      kd_split(lo + n / 2, n - n / 2, lvl + 1, dims);
    endfunction

    function void note_point(point_t pt, logic last);
      int dims;
      kd_result_t r;
      if (n_pts >= kdpo_pkg::MAX_POINTS_DEF) n_pts = 0;
      pts[n_pts] = pt;
      n_pts++;
      if (!last && n_pts < kdpo_pkg::MAX_POINTS_DEF) return;
      dims = (dims_reg == 0) ? 1
           : (dims_reg > kdpo_pkg::MAX_DIMS) ? kdpo_pkg::MAX_DIMS : int'(dims_reg);
      kd_split(0, n_pts, 0, dims);
      for (int k = 0; k < n_pts; k++) begin
        r.pt   = pts[k];
        r.last = (k + 1 == n_pts);
        pending_q.push_back(r);
      end
      n_pts = 0;
    endfunction

    function void check_result(point_t pt, logic last);
      kd_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        $error("unexpected result item %h last=%0b", pt, last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      for (int d = 0; d < 3; d++) begin
        if (pt[d*kdpo_pkg::COORD_W +: kdpo_pkg::COORD_W] !==
            e.pt[d*kdpo_pkg::COORD_W +: kdpo_pkg::COORD_W]) begin
          $error("out_%s mismatch: expected %h actual %h",
                 d == 0 ? "a" : d == 1 ? "b" : "c",
                 e.pt[d*kdpo_pkg::COORD_W +: kdpo_pkg::COORD_W],
                 pt[d*kdpo_pkg::COORD_W +: kdpo_pkg::COORD_W]);
          errors++;
        end
      end
      if (last !== e.last) begin
        $error("out_last mismatch: expected %0b actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  point_t     in_tdata;    // coord_a, coord_b, coord_c
  logic       in_tlast;    // last_point
  logic       out_tvalid;
  logic       out_tready;
  point_t     out_tdata;   // out_a, out_b, out_c
  logic       out_tlast;   // out_last
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [1:0] cfg_data;

  kd_order_board board;
  int            cycle_cnt;
  int            rand_items;
  bit            rx_burst;   // receiver runs without idling while set
  bit            tx_burst;

  kd_tree_point_order u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit: covers the ordering of a full set, stalls and gaps many times over
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > 600000) begin
        $display("kd_tree_point_order verification failed");
        $finish;
      end
    end
  end

  // result monitor, sampled at the clock edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);
  end

  // receiver: random stalls, burst stretches, and one long hold-off so the block backs up
  initial begin : rx_proc
    int  gap;
    bit  held;
    held       = 0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // early in the first set, while the sender already offers the next point
      if (!held && board.checked >= 2) begin
        held       = 1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_point(point_t pt, logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pt;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    board.note_point(pt, last);
  endtask

  task automatic write_cfg(logic idx, logic [1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected item, then let the block settle before touching config
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4);   // small values, many ties
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h8000_0001;
          default: return 32'h0;
        endcase
      end
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;  // +-1.0, equal magnitude
      default: return {{16{1'b0}}, 16'($urandom())} ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 0);
    endcase
  endfunction

  function automatic point_t rand_point();
    return {pick_coord(), pick_coord(), pick_coord()};
  endfunction

  // one random set of a few points, closed by the last marker
  task automatic send_rand_set();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      send_point(rand_point(), i == n - 1);
      rand_items++;
    end
  endtask

  initial begin : main_proc
    logic [1:0] dims_set[7];
    logic [1:0] start_set[7];
    board      = new();
    rand_items = 0;
    rx_burst   = 0;
    tx_burst   = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = kdpo_pkg::CFG_DIMS;
    cfg_data   = 2'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, extremes, equal magnitudes of both signs, lone point
    send_point({32'h0, 32'h8000_0000, 32'h7fff_ffff}, 1'b0);
    send_point({32'h1, 32'h7fff_ffff, 32'h8000_0000}, 1'b0);
    send_point({32'h2, 32'hffff_ffff, 32'h0000_0001}, 1'b0);
    send_point({32'h3, 32'h0000_0001, 32'hffff_ffff}, 1'b0);
    send_point({32'h4, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    send_point({32'h5, 32'hffff_0000, 32'h0001_0000}, 1'b0);
    send_point({32'h6, 32'h0001_0000, 32'hffff_0000}, 1'b0);
    send_point({32'h7, 32'h8000_0001, 32'h7fff_ffff}, 1'b1);
    send_point({32'hdead_beef, 32'h8000_0000, 32'h1234_5678}, 1'b1);
    drain();

    // directed: three axes, start offset, full store closed by count without last marker
    write_cfg(kdpo_pkg::CFG_DIMS, 2'd3);
    write_cfg(kdpo_pkg::CFG_START, 2'd2);
    tx_burst = 1;
    for (int i = 0; i < kdpo_pkg::MAX_POINTS_DEF; i++) send_point(rand_point(), 1'b0);
    tx_burst = 0;
    drain();

    // random phases over a spread of settings, zero and out-of-range included
    dims_set  = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd1, 2'd2};
    start_set = '{2'd0, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2, 2'd2};
    for (int p = 0; p < 7 || rand_items < 40; p++) begin
      write_cfg(kdpo_pkg::CFG_DIMS, dims_set[p % 7]);
      write_cfg(kdpo_pkg::CFG_START, start_set[p % 7]);
      rx_burst = (p % 3 == 1);
      tx_burst = (p % 4 == 2);
      send_rand_set();
      drain();
    end

    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("kd_tree_point_order verification clean");
    end else begin
      $display("kd_tree_point_order verification failed");
    end
    $finish;
  end

endmodule
